@@ sv/k_nearest_point_selection_defines.svh @@
// Assertion macros for the k-nearest point selection block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef K_NEAREST_POINT_SELECTION_DEFINES_SVH
`define K_NEAREST_POINT_SELECTION_DEFINES_SVH

// checked property, off while in reset
`define KNS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property, also during reset
`define KNS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/kns_pkg.sv @@
// Shared types and constants of the k-nearest point selection block.
// No dependencies.
`default_nettype none

package kns_pkg;

    localparam int MAX_KEEP    = 16;
    localparam int COORD_W     = 24;
    localparam int INDEX_W     = 24;
    localparam int KEEP_W      = 5;
    localparam int RANK_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int DIST_W      = 2 * DIFF_W;
    localparam int COUNT_W     = $clog2(MAX_KEEP + 1);

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0]         sq_dist;
        logic [INDEX_W-1:0]        idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } entry_t;

    typedef struct packed {
        logic   valid;
        logic   last;
        entry_t ent;
    } cand_t;

    typedef struct packed {
        logic ins;
        logic pop;
        logic valid;
        logic in_range;
        logic at_fill;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/k_nearest_point_selection.sv @@
// Top level of the k-nearest point selection block: registers, chain of slots, drain.
// Depends on kns_pkg, kns_dist, kns_cell and k_nearest_point_selection_defines.svh.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------------
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in_valid / in_ready    | cand_x, cand_y, cand_z, cand_index, last_point
//  out     | out_valid / out_ready  | rank, out_index, out_x, out_y, out_z, out_last
//
// One item per cycle while input is open; kns_dist computes the distance, then the
// item enters the slot chain. A last item closes input until its results are taken:
// kept entries leave one per cycle via the output register while out_ready is high.
// Reset clears counters and control; slots hold no reset value and need no clearing.
// out stalls freeze the drain; cfg is always ready.
`default_nettype none
`include "k_nearest_point_selection_defines.svh"

module k_nearest_point_selection (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [kns_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [kns_pkg::COORD_W-1:0]         cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [kns_pkg::COORD_W-1:0]  cand_x,
    input  wire logic signed [kns_pkg::COORD_W-1:0]  cand_y,
    input  wire logic signed [kns_pkg::COORD_W-1:0]  cand_z,
    input  wire logic [kns_pkg::INDEX_W-1:0]         cand_index,
    input  wire logic                                last_point,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [kns_pkg::RANK_W-1:0]               rank,
    output logic [kns_pkg::INDEX_W-1:0]              out_index,
    output logic signed [kns_pkg::COORD_W-1:0]       out_x,
    output logic signed [kns_pkg::COORD_W-1:0]       out_y,
    output logic signed [kns_pkg::COORD_W-1:0]       out_z,
    output logic                                     out_last
);

    localparam int N  = kns_pkg::MAX_KEEP;
    localparam int CW = kns_pkg::COUNT_W;

    logic signed [kns_pkg::COORD_W-1:0] query_x_reg, query_y_reg, query_z_reg;
    logic [kns_pkg::KEEP_W-1:0]         keep_count_reg;
    logic [CW-1:0]                      filled_reg, filled_next;
    logic                               drain_reg, drain_next;
    logic                               busy_reg, busy_next;
    logic [kns_pkg::RANK_W-1:0]         rank_reg, rank_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               out_last_reg;
    kns_pkg::entry_t                    out_ent_reg;

    logic                               in_fire, out_fire, pop, inserted;
    logic [CW-1:0]                      k_eff, filled_eff;
    kns_pkg::cand_t                     cand;
    kns_pkg::cell_ctl_t                 ctl [N];
    kns_pkg::entry_t                    ents [N];
    logic                               hits [N];

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign pop       = drain_reg && (!out_valid_reg || out_ready) && (filled_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg    <= '0;
            query_y_reg    <= '0;
            query_z_reg    <= '0;
            keep_count_reg <= kns_pkg::KEEP_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kns_pkg::REG_QUERY_X:    query_x_reg    <= cfg_data;
                kns_pkg::REG_QUERY_Y:    query_y_reg    <= cfg_data;
                kns_pkg::REG_QUERY_Z:    query_z_reg    <= cfg_data;
                kns_pkg::REG_KEEP_COUNT: keep_count_reg <= cfg_data[kns_pkg::KEEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (keep_count_reg == '0)
            k_eff = CW'(1);
        else if (int'(keep_count_reg) > N)
            k_eff = CW'(N);
        else
            k_eff = CW'(keep_count_reg);
        filled_eff = (filled_reg > k_eff) ? k_eff : filled_reg;
    end

    kns_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .cand_x     (cand_x),
        .cand_y     (cand_y),
        .cand_z     (cand_z),
        .cand_index (cand_index),
        .last_point (last_point),
        .query_x    (query_x_reg),
        .query_y    (query_y_reg),
        .query_z    (query_z_reg),
        .cand       (cand)
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        kns_pkg::entry_t left_ent, right_ent;
        logic            prev_hit;

        always_comb
        begin
            ctl[i].ins      = cand.valid;
            ctl[i].pop      = pop;
            ctl[i].valid    = CW'(i) < filled_eff;
            ctl[i].in_range = CW'(i) < k_eff;
            ctl[i].at_fill  = CW'(i) == filled_eff;
        end

        if (i == 0)
        begin : g_head
            assign left_ent = cand.ent;
            assign prev_hit = 1'b0;
        end
        else
        begin : g_body
            assign left_ent = ents[i-1];
            assign prev_hit = hits[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign right_ent = ents[i];
        end
        else
        begin : g_mid
            assign right_ent = ents[i+1];
        end

        kns_cell u_cell (
            .clk       (clk),
            .ctl       (ctl[i]),
            .prev_hit  (prev_hit),
            .new_ent   (cand.ent),
            .left_ent  (left_ent),
            .right_ent (right_ent),
            .hit       (hits[i]),
            .ent       (ents[i])
        );
    end

    assign inserted = hits[N-1] || (filled_eff < k_eff);

    always_comb
    begin
        filled_next    = filled_reg;
        drain_next     = drain_reg;
        busy_next      = busy_reg;
        rank_next      = rank_reg;
        out_valid_next = out_valid_reg;

        if (cand.valid)
        begin
            filled_next = (inserted && (filled_eff < k_eff)) ? filled_eff + CW'(1) : filled_eff;
            if (cand.last)
            begin
                drain_next = 1'b1;
                rank_next  = '0;
            end
        end
        else if (pop)
        begin
            filled_next = filled_reg - CW'(1);
            rank_next   = rank_reg + kns_pkg::RANK_W'(1);
            if (filled_reg == CW'(1))
                drain_next = 1'b0;
        end

        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;

        if (in_fire && last_point)
            busy_next = 1'b1;
        else if (out_fire && out_last_reg)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= '0;
            drain_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            filled_reg    <= filled_next;
            drain_reg     <= drain_next;
            busy_reg      <= busy_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_ent_reg  <= ents[0];
            out_last_reg <= filled_reg == CW'(1);
        end
    end

    logic [kns_pkg::RANK_W-1:0] rank_out_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
            rank_out_reg <= rank_reg;
    end

    assign out_valid = out_valid_reg;
    assign rank      = rank_out_reg;
    assign out_index = out_ent_reg.idx;
    assign out_x     = out_ent_reg.x;
    assign out_y     = out_ent_reg.y;
    assign out_z     = out_ent_reg.z;
    assign out_last  = out_last_reg;

    `KNS_ASSERT(a_fill_bound, filled_reg <= CW'(N), "slot count beyond chain length")
    `KNS_ASSERT(a_no_insert_in_drain, cand.valid |-> !drain_reg, "insert during drain")
    `KNS_ASSERT(a_drain_ends_empty, out_fire && out_last_reg |=> !busy_reg && filled_reg == '0,
        "list not empty after final result")
    `KNS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_reg && !busy_reg,
        "output or busy set in reset")

endmodule

`default_nettype wire

@@ sv/kns_dist.sv @@
// Three-stage squared distance pipeline: differences, squares, sum.
// Depends on kns_pkg.
`default_nettype none

module kns_dist (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_fire,
    input  wire logic signed [kns_pkg::COORD_W-1:0] cand_x,
    input  wire logic signed [kns_pkg::COORD_W-1:0] cand_y,
    input  wire logic signed [kns_pkg::COORD_W-1:0] cand_z,
    input  wire logic [kns_pkg::INDEX_W-1:0]   cand_index,
    input  wire logic                          last_point,
    input  wire logic signed [kns_pkg::COORD_W-1:0] query_x,
    input  wire logic signed [kns_pkg::COORD_W-1:0] query_y,
    input  wire logic signed [kns_pkg::COORD_W-1:0] query_z,
    output kns_pkg::cand_t                     cand
);

    logic                                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    kns_pkg::cand_t                      s1_reg, s2_reg, s3_reg, s3_next;
    logic signed [kns_pkg::DIFF_W-1:0]   dx_reg, dy_reg, dz_reg;
    logic signed [kns_pkg::DIST_W-1:0]   dx_sq, dy_sq, dz_sq;
    logic [kns_pkg::DIST_W-1:0]          sx_reg, sy_reg, sz_reg;
    logic [kns_pkg::DIST_W-1:0]          sum_next;

    assign dx_sq    = dx_reg * dx_reg;
    assign dy_sq    = dy_reg * dy_reg;
    assign dz_sq    = dz_reg * dz_reg;
    assign sum_next = sx_reg + sy_reg + sz_reg;

    always_comb
    begin
        s3_next             = s2_reg;
        s3_next.ent.sq_dist = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= {cand_x[kns_pkg::COORD_W-1], cand_x} - {query_x[kns_pkg::COORD_W-1], query_x};
        dy_reg <= {cand_y[kns_pkg::COORD_W-1], cand_y} - {query_y[kns_pkg::COORD_W-1], query_y};
        dz_reg <= {cand_z[kns_pkg::COORD_W-1], cand_z} - {query_z[kns_pkg::COORD_W-1], query_z};
        s1_reg.valid       <= 1'b0;
        s1_reg.last        <= last_point;
        s1_reg.ent.sq_dist <= '0;
        s1_reg.ent.idx     <= cand_index;
        s1_reg.ent.x       <= cand_x;
        s1_reg.ent.y       <= cand_y;
        s1_reg.ent.z       <= cand_z;

        sx_reg <= unsigned'(dx_sq);
        sy_reg <= unsigned'(dy_sq);
        sz_reg <= unsigned'(dz_sq);
        s2_reg <= s1_reg;

        s3_reg <= s3_next;
    end

    always_comb
    begin
        cand       = s3_reg;
        cand.valid = s3_valid_reg;
    end

endmodule

`default_nettype wire

@@ sv/kns_cell.sv @@
// One slot of the sorted chain: compares, inserts, shifts up on insert, down on drain.
// Depends on kns_pkg.
`default_nettype none

module kns_cell (
    input  wire logic                       clk,
    input  wire kns_pkg::cell_ctl_t         ctl,
    input  wire logic                       prev_hit,
    input  wire kns_pkg::entry_t            new_ent,
    input  wire kns_pkg::entry_t            left_ent,
    input  wire kns_pkg::entry_t            right_ent,
    output logic                            hit,
    output kns_pkg::entry_t                 ent
);

    kns_pkg::entry_t ent_reg, ent_next;
    logic            le;

    assign le  = ctl.valid && (new_ent.sq_dist <= ent_reg.sq_dist);
    assign hit = prev_hit || le;
    assign ent = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.ins && ctl.in_range)
        begin
            if (prev_hit)
                ent_next = left_ent;
            else if (le || ctl.at_fill)
                ent_next = new_ent;
        end
        else if (ctl.pop)
        begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

@@ tb/k_nearest_point_selection_tb.sv @@
// Self-checking testbench for k_nearest_point_selection: a tracker class predicts the
// ranked points of every query while tasks drive candidates and register writes.
// Depends on kns_pkg and the k_nearest_point_selection RTL.
`timescale 1ns / 100ps

module k_nearest_point_selection_tb;

    localparam logic signed [kns_pkg::COORD_W-1:0] C_MAX =
        {1'b0, {(kns_pkg::COORD_W-1){1'b1}}};
    localparam logic signed [kns_pkg::COORD_W-1:0] C_MIN =
        {1'b1, {(kns_pkg::COORD_W-1){1'b0}}};
    localparam int RANDOM_ITEMS = 136;

    typedef struct packed {
        logic [kns_pkg::RANK_W-1:0]         rank;
        logic [kns_pkg::INDEX_W-1:0]        idx;
        logic signed [kns_pkg::COORD_W-1:0] x;
        logic signed [kns_pkg::COORD_W-1:0] y;
        logic signed [kns_pkg::COORD_W-1:0] z;
        logic                               last;
    } ranked_point_t;

    class nearest_tracker;
        logic signed [kns_pkg::COORD_W-1:0] qx, qy, qz;
        logic [kns_pkg::KEEP_W-1:0]         keep_reg;
        longint unsigned                    s_dist [kns_pkg::MAX_KEEP];
        logic [kns_pkg::INDEX_W-1:0]        s_idx [kns_pkg::MAX_KEEP];
        logic signed [kns_pkg::COORD_W-1:0] s_x [kns_pkg::MAX_KEEP];
        logic signed [kns_pkg::COORD_W-1:0] s_y [kns_pkg::MAX_KEEP];
        logic signed [kns_pkg::COORD_W-1:0] s_z [kns_pkg::MAX_KEEP];
        int                                 filled;
        ranked_point_t                      pending[$];
        int                                 errors;
        int                                 n_points;
        int                                 n_results;
        int                                 n_queries;

        function new();
            qx = '0;
            qy = '0;
            qz = '0;
            keep_reg = kns_pkg::KEEP_W'(kns_pkg::MAX_KEEP);
            filled = 0;
            errors = 0;
            n_points = 0;
            n_results = 0;
            n_queries = 0;
        endfunction

        function void write_reg(logic [kns_pkg::CFG_IDX_W-1:0] idx,
                                logic [kns_pkg::COORD_W-1:0] data);
            case (idx)
                kns_pkg::REG_QUERY_X:    qx = data;
                kns_pkg::REG_QUERY_Y:    qy = data;
                kns_pkg::REG_QUERY_Z:    qz = data;
                kns_pkg::REG_KEEP_COUNT: keep_reg = data[kns_pkg::KEEP_W-1:0];
                default:                 ;
            endcase
        endfunction

        function longint unsigned axis_sq(logic signed [kns_pkg::COORD_W-1:0] a,
                                          logic signed [kns_pkg::COORD_W-1:0] b);
            longint d;
            d = longint'(a) - longint'(b);
            return d * d;
        endfunction

        function void note_point(logic signed [kns_pkg::COORD_W-1:0] cx,
                                 logic signed [kns_pkg::COORD_W-1:0] cy,
                                 logic signed [kns_pkg::COORD_W-1:0] cz,
                                 logic [kns_pkg::INDEX_W-1:0] cid, logic last);
            int              k;
            int              pos;
            int              top;
            int              i;
            longint unsigned d;
            ranked_point_t   r;
            n_points++;
            if (keep_reg == 0)
                k = 1;
            else if (keep_reg > kns_pkg::MAX_KEEP)
                k = kns_pkg::MAX_KEEP;
            else
                k = int'(keep_reg);
            if (filled > k)
                filled = k;
            d = axis_sq(cx, qx) + axis_sq(cy, qy) + axis_sq(cz, qz);
            pos = filled;
            for (i = filled - 1; i >= 0; i--)
                if (d <= s_dist[i])
                    pos = i;
            if (pos < k)
            begin
                top = (filled < k) ? filled : k - 1;
                for (i = top; i > pos; i--)
                begin
                    s_dist[i] = s_dist[i-1];
                    s_idx[i]  = s_idx[i-1];
                    s_x[i]    = s_x[i-1];
                    s_y[i]    = s_y[i-1];
                    s_z[i]    = s_z[i-1];
                end
                s_dist[pos] = d;
                s_idx[pos]  = cid;
                s_x[pos]    = cx;
                s_y[pos]    = cy;
                s_z[pos]    = cz;
                if (filled < k)
                    filled++;
            end
            if (last)
            begin
                n_queries++;
                for (i = 0; i < filled; i++)
                begin
                    r.rank = kns_pkg::RANK_W'(i);
                    r.idx  = s_idx[i];
                    r.x    = s_x[i];
                    r.y    = s_y[i];
                    r.z    = s_z[i];
                    r.last = (i == filled - 1);
                    pending = {pending, r};
                end
                filled = 0;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_result(logic [kns_pkg::RANK_W-1:0] rk, logic [kns_pkg::INDEX_W-1:0] id,
                          logic signed [kns_pkg::COORD_W-1:0] x,
                          logic signed [kns_pkg::COORD_W-1:0] y,
                          logic signed [kns_pkg::COORD_W-1:0] z, logic lst);
            ranked_point_t w;
            n_results++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result rank %0d index %0h", rk, id));
                return;
            end
            w = pending.pop_front();
            if (rk !== w.rank)
                report($sformatf("rank got %0d want %0d", rk, w.rank));
            if (id !== w.idx)
                report($sformatf("rank %0d out_index got %0h want %0h", w.rank, id, w.idx));
            if (x !== w.x)
                report($sformatf("rank %0d out_x got %0d want %0d", w.rank, x, w.x));
            if (y !== w.y)
                report($sformatf("rank %0d out_y got %0d want %0d", w.rank, y, w.y));
            if (z !== w.z)
                report($sformatf("rank %0d out_z got %0d want %0d", w.rank, z, w.z));
            if (lst !== w.last)
                report($sformatf("rank %0d out_last got %0b want %0b", w.rank, lst, w.last));
        endtask
    endclass

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [kns_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [kns_pkg::COORD_W-1:0]          cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic signed [kns_pkg::COORD_W-1:0]   cand_x = '0;
    logic signed [kns_pkg::COORD_W-1:0]   cand_y = '0;
    logic signed [kns_pkg::COORD_W-1:0]   cand_z = '0;
    logic [kns_pkg::INDEX_W-1:0]          cand_index = '0;
    logic                                 last_point = 1'b0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic [kns_pkg::RANK_W-1:0]           rank;
    logic [kns_pkg::INDEX_W-1:0]          out_index;
    logic signed [kns_pkg::COORD_W-1:0]   out_x;
    logic signed [kns_pkg::COORD_W-1:0]   out_y;
    logic signed [kns_pkg::COORD_W-1:0]   out_z;
    logic                                 out_last;

    nearest_tracker sb;
    bit             tx_calm = 1'b0;
    bit             rx_calm = 1'b0;
    int             stall_left = 0;
    int             sent = 0;
    int             cfg_writes = 0;

    k_nearest_point_selection uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cand_x     (cand_x),
        .cand_y     (cand_y),
        .cand_z     (cand_z),
        .cand_index (cand_index),
        .last_point (last_point),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rank       (rank),
        .out_index  (out_index),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .out_last   (out_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // monitors on all three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_point(cand_x, cand_y, cand_z, cand_index, last_point);
            if (out_valid && out_ready)
                sb.check_result(rank, out_index, out_x, out_y, out_z, out_last);
        end
    end

    // receiver stalls, drawn per item and now and then while idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                stall_left = rx_calm ? 0 : $urandom_range(0, 15);
            else if (!out_valid && stall_left == 0 && !rx_calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 15);
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task write_reg(logic [kns_pkg::CFG_IDX_W-1:0] idx, logic [kns_pkg::COORD_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task set_query(logic signed [kns_pkg::COORD_W-1:0] x, logic signed [kns_pkg::COORD_W-1:0] y,
                   logic signed [kns_pkg::COORD_W-1:0] z);
        write_reg(kns_pkg::REG_QUERY_X, x);
        write_reg(kns_pkg::REG_QUERY_Y, y);
        write_reg(kns_pkg::REG_QUERY_Z, z);
    endtask

    // upper data bits are don't-care for the keep register
    task set_keep(int k);
        logic [kns_pkg::COORD_W-1:0] d;
        d = kns_pkg::COORD_W'($urandom);
        d[kns_pkg::KEEP_W-1:0] = kns_pkg::KEEP_W'(k);
        write_reg(kns_pkg::REG_KEEP_COUNT, d);
    endtask

    task offer_point(logic signed [kns_pkg::COORD_W-1:0] x,
                     logic signed [kns_pkg::COORD_W-1:0] y,
                     logic signed [kns_pkg::COORD_W-1:0] z,
                     logic [kns_pkg::INDEX_W-1:0] id, logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cand_x     <= x;
        cand_y     <= y;
        cand_z     <= z;
        cand_index <= id;
        last_point <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // hold input until every expected result is in, then let the pipeline empty
    task settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic signed [kns_pkg::COORD_W-1:0] pick_coord(
        logic signed [kns_pkg::COORD_W-1:0] c);
        int m;
        m = $urandom_range(0, 9);
        if (m == 0)
            return C_MAX;
        if (m == 1)
            return C_MIN;
        if (m < 6)
            return kns_pkg::COORD_W'(c + $urandom_range(0, 6) - 3);
        return kns_pkg::COORD_W'($urandom);
    endfunction

    function automatic logic signed [kns_pkg::COORD_W-1:0] pick_center();
        int m;
        m = $urandom_range(0, 7);
        if (m == 0)
            return C_MAX;
        if (m == 1)
            return C_MIN;
        if (m == 2)
            return '0;
        return kns_pkg::COORD_W'($urandom);
    endfunction

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset config: query at origin, keep 16; lone point, then ties at equal distance
        offer_point(0, 0, 0, 0, 1'b1);
        offer_point(5, 0, 0, 1, 1'b0);
        offer_point(-5, 0, 0, 2, 1'b0);
        offer_point(0, 0, 5, 3, 1'b0);
        offer_point(C_MAX, C_MAX, C_MAX, {kns_pkg::INDEX_W{1'b1}}, 1'b0);
        offer_point(C_MIN, C_MIN, C_MIN, 4, 1'b0);
        offer_point(0, -5, 0, 5, 1'b1);
        settle();

        // extreme query, keep one, largest distances
        set_query(C_MIN, C_MAX, C_MIN);
        set_keep(1);
        offer_point(C_MAX, C_MIN, C_MAX, 6, 1'b0);
        offer_point(C_MIN, C_MAX, C_MIN, 7, 1'b0);
        offer_point(C_MIN + kns_pkg::COORD_W'(1), C_MAX, C_MIN, 8, 1'b0);
        offer_point(0, 0, 0, 9, 1'b1);
        settle();

        // keep count zero acts as one
        set_query(1, 2, 3);
        set_keep(0);
        offer_point(9, 9, 9, 10, 1'b0);
        offer_point(1, 2, 4, 11, 1'b0);
        offer_point(C_MAX, 2, 3, 12, 1'b1);
        settle();

        // keep count above the maximum acts as the maximum
        set_query(0, 0, 0);
        set_keep(31);
        offer_point(3, 3, 3, 13, 1'b0);
        offer_point(-1, -1, -1, 14, 1'b0);
        offer_point(2, 2, 2, 15, 1'b1);
        settle();

        // keep count lowered part way through a query
        set_keep(16);
        offer_point(6, 0, 0, 16, 1'b0);
        offer_point(1, 0, 0, 17, 1'b0);
        offer_point(4, 0, 0, 18, 1'b0);
        offer_point(2, 0, 0, 19, 1'b0);
        offer_point(5, 0, 0, 20, 1'b0);
        offer_point(3, 0, 0, 21, 1'b0);
        settle();
        set_keep(3);
        offer_point(7, 0, 0, 22, 1'b1);
        settle();

        // random queries
        while (sent < 24 + RANDOM_ITEMS)
        begin
            int                                 nq;
            int                                 len;
            int                                 kc;
            int                                 j;
            logic signed [kns_pkg::COORD_W-1:0] qx, qy, qz;
            settle();
            qx = pick_center();
            qy = pick_center();
            qz = pick_center();
            set_query(qx, qy, qz);
            kc = $urandom_range(0, 19);
            if (kc == 0)
                set_keep(0);
            else if (kc == 1)
                set_keep($urandom_range(17, 31));
            else if (kc == 2)
                set_keep(1);
            else if (kc == 3)
                set_keep(kns_pkg::MAX_KEEP);
            else
                set_keep($urandom_range(1, kns_pkg::MAX_KEEP));
            nq = $urandom_range(1, 3);
            repeat (nq)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, 12);
                for (j = 0; j < len; j++)
                    offer_point(pick_coord(qx), pick_coord(qy), pick_coord(qz),
                                kns_pkg::INDEX_W'($urandom), j == len - 1);
            end
        end
        settle();
        repeat (20) @(posedge clk);

        $display("covered %0d points in %0d queries, %0d ranked results checked",
                 sb.n_points, sb.n_queries, sb.n_results);
        $display("%0d register writes, keep counts from zero to 31, %0d mismatches",
                 cfg_writes, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("k_nearest_point_selection_tb: clean");
        else
            $display("k_nearest_point_selection_tb: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout, %0d results still expected", sb.pending.size());
        $display("k_nearest_point_selection_tb: errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/kns_pkg.sv
sv/kns_dist.sv
sv/kns_cell.sv
sv/k_nearest_point_selection.sv
tb/k_nearest_point_selection_tb.sv
